@@ rtl/core/assert_macros.svh @@
// Assertion shorthands for the glyph blitter checkers.
// Each expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AGCB_ASSERT_IMP(lbl, pre, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
        else $error("agcb assertion failed");

// next-cycle implication
`define AGCB_ASSERT_NXT(lbl, pre, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
        else $error("agcb assertion failed");

`endif

@@ rtl/core/agcb_pkg.sv @@
`default_nettype none

package agcb_pkg;

    localparam int LANES    = 4;     // alpha codes per data byte
    localparam int LANE_W   = 2;
    localparam int CODE_W   = 2;
    localparam int DIM_W    = 7;     // glyph dimensions, 1..64 accepted
    localparam int COORD_W  = 10;
    localparam int COLOR_W  = 16;
    localparam int POS_W    = 14;    // signed placement math
    localparam int AREA_W   = 13;
    localparam int BASE_W   = 6;
    localparam int CIDX_W   = 2;
    localparam int IN_W     = 64;
    localparam int OUT_W    = 56;

    localparam logic [DIM_W-1:0] MAX_DIM = 7'd64;

    localparam int DEFAULT_SCREEN_WIDTH  = 320;
    localparam int DEFAULT_SCREEN_HEIGHT = 240;
    localparam int DEFAULT_MAX_AREA      = 3072;

    localparam logic [COLOR_W-1:0] FG_RESET   = 16'hFFFF;
    localparam logic [COLOR_W-1:0] BG_RESET   = 16'h0000;
    localparam logic [BASE_W-1:0]  BASE_RESET = 6'd15;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_FG_COLOR    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BG_COLOR    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_BASELINE    = 2'd2;

    // result kinds
    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    // input modes
    localparam logic MODE_HEADER = 1'b0;
    localparam logic MODE_DATA   = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0]   start_col;
        logic [DIM_W-1:0]   start_row;
        logic [DIM_W-1:0]   end_col;
        logic [DIM_W-1:0]   end_row;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [COORD_W-1:0] org_x;
        logic [COORD_W-1:0] org_y;
    } geom_t;

    typedef struct packed {
        logic               load;
        geom_t              geom;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } hdr_res_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
        logic [COLOR_W-1:0] color;
    } lane_res_t;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
        logic [COLOR_W-1:0] color;
        logic               last;
    } out_t;

    function automatic logic [7:0] alpha_of(input logic [CODE_W-1:0] code);
        logic [7:0] a;
        case (code)
            2'd0:    a = 8'd0;
            2'd1:    a = 8'd85;
            2'd2:    a = 8'd170;
            default: a = 8'd255;
        endcase
        return a;
    endfunction

    // per channel (f*a + b*(255-a)) >> 8
    function automatic logic [COLOR_W-1:0] blend(input logic [COLOR_W-1:0] fg,
                                                 input logic [COLOR_W-1:0] bg,
                                                 input logic [CODE_W-1:0]  code);
        logic [7:0]  a;
        logic [7:0]  ia;
        logic [12:0] r;
        logic [13:0] g;
        logic [12:0] b;
        a  = alpha_of(code);
        ia = 8'd255 - a;
        r  = {8'd0, fg[15:11]} * {5'd0, a} + {8'd0, bg[15:11]} * {5'd0, ia};
        g  = {8'd0, fg[10:5]}  * {6'd0, a} + {8'd0, bg[10:5]}  * {6'd0, ia};
        b  = {8'd0, fg[4:0]}   * {5'd0, a} + {8'd0, bg[4:0]}   * {5'd0, ia};
        return {r[12:8], g[13:8], b[12:8]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/agcb_hdr.sv @@
`default_nettype none

// Header placement and clipping, three stages.
module agcb_hdr #(
    parameter int SCREEN_WIDTH  = agcb_pkg::DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = agcb_pkg::DEFAULT_SCREEN_HEIGHT,
    parameter int MAX_AREA      = agcb_pkg::DEFAULT_MAX_AREA
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [11:0]                 pen_x,
    input  wire logic signed [11:0]                 pen_y,
    input  wire logic [agcb_pkg::DIM_W-1:0]         glyph_width,
    input  wire logic [agcb_pkg::DIM_W-1:0]         glyph_height,
    input  wire logic signed [agcb_pkg::DIM_W-1:0]  offset_x,
    input  wire logic signed [agcb_pkg::DIM_W-1:0]  offset_y,
    input  wire logic [agcb_pkg::BASE_W-1:0]        baseline_offset,
    output logic                                    busy,
    output agcb_pkg::hdr_res_t                      res
);

    localparam logic signed [agcb_pkg::POS_W-1:0] SW_S =
        agcb_pkg::POS_W'(SCREEN_WIDTH);
    localparam logic signed [agcb_pkg::POS_W-1:0] SH_S =
        agcb_pkg::POS_W'(SCREEN_HEIGHT);
    localparam logic [agcb_pkg::AREA_W-1:0] AREA_MAX =
        agcb_pkg::AREA_W'(MAX_AREA);

    // stage 1: corner position
    logic                                  s1_valid_reg;
    logic signed [agcb_pkg::POS_W-1:0]     gx_reg, gy_reg;
    logic [agcb_pkg::DIM_W-1:0]            w_reg, h_reg;
    logic                                  bad_reg;

    // stage 2: clip window
    logic                                  s2_valid_reg;
    logic                                  ok_reg;
    logic [agcb_pkg::DIM_W-1:0]            sx_reg, sy_reg, ex_reg, ey_reg;
    logic [agcb_pkg::DIM_W-1:0]            w2_reg, h2_reg, vw_reg, vh_reg;
    logic [agcb_pkg::COORD_W-1:0]          gxc_reg, gyc_reg;

    logic signed [agcb_pkg::POS_W-1:0]     gx_next, gy_next;
    logic signed [agcb_pkg::POS_W-1:0]     gxc, gyc, sx, sy, exw, eyw, w_s, h_s;
    logic                                  ok_next;
    logic [agcb_pkg::AREA_W-1:0]           area;

    always_comb
    begin
        gx_next = agcb_pkg::POS_W'(pen_x) + agcb_pkg::POS_W'(offset_x);
        gy_next = agcb_pkg::POS_W'(pen_y) + $signed({8'd0, baseline_offset})
                + agcb_pkg::POS_W'(offset_y);
    end

    always_comb
    begin
        w_s = $signed({7'd0, w_reg});
        h_s = $signed({7'd0, h_reg});
        gxc = gx_reg[agcb_pkg::POS_W-1] ? '0 : gx_reg;
        gyc = gy_reg[agcb_pkg::POS_W-1] ? '0 : gy_reg;
        sx  = gx_reg[agcb_pkg::POS_W-1] ? -gx_reg : '0;
        sy  = gy_reg[agcb_pkg::POS_W-1] ? -gy_reg : '0;
        exw = (gxc + w_s > SW_S) ? SW_S - gxc : w_s;
        eyw = (gyc + h_s > SH_S) ? SH_S - gyc : h_s;
        ok_next = !bad_reg && (sx < exw) && (sy < eyw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            gx_reg  <= gx_next;
            gy_reg  <= gy_next;
            w_reg   <= glyph_width;
            h_reg   <= glyph_height;
            bad_reg <= (glyph_width == '0) || (glyph_height == '0)
                    || (glyph_width > agcb_pkg::MAX_DIM)
                    || (glyph_height > agcb_pkg::MAX_DIM);
        end
        if (s1_valid_reg)
        begin
            ok_reg  <= ok_next;
            sx_reg  <= sx[agcb_pkg::DIM_W-1:0];
            sy_reg  <= sy[agcb_pkg::DIM_W-1:0];
            ex_reg  <= exw[agcb_pkg::DIM_W-1:0];
            ey_reg  <= eyw[agcb_pkg::DIM_W-1:0];
            vw_reg  <= exw[agcb_pkg::DIM_W-1:0] - sx[agcb_pkg::DIM_W-1:0];
            vh_reg  <= eyw[agcb_pkg::DIM_W-1:0] - sy[agcb_pkg::DIM_W-1:0];
            w2_reg  <= w_reg;
            h2_reg  <= h_reg;
            gxc_reg <= gxc[agcb_pkg::COORD_W-1:0];
            gyc_reg <= gyc[agcb_pkg::COORD_W-1:0];
        end
    end

    // stage 3: area limit, results registered by the consumer
    always_comb
    begin
        area = {6'd0, vw_reg} * {6'd0, vh_reg};
        res.load            = s2_valid_reg && ok_reg && (area <= AREA_MAX);
        res.geom.start_col  = sx_reg;
        res.geom.start_row  = sy_reg;
        res.geom.end_col    = ex_reg;
        res.geom.end_row    = ey_reg;
        res.geom.width      = w2_reg;
        res.geom.height     = h2_reg;
        res.geom.org_x      = gxc_reg;
        res.geom.org_y      = gyc_reg;
        res.right  = gxc_reg + agcb_pkg::COORD_W'(vw_reg) - 10'd1;
        res.bottom = gyc_reg + agcb_pkg::COORD_W'(vh_reg) - 10'd1;
    end

    assign busy = s1_valid_reg || s2_valid_reg;

endmodule

`default_nettype wire

@@ rtl/core/agcb_lane.sv @@
`default_nettype none

// One alpha code: bitmap walk step, clip test, screen position, blend.
module agcb_lane (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire logic                          take,
    input  wire logic                          active,
    input  wire agcb_pkg::geom_t               geom,
    input  wire logic [agcb_pkg::DIM_W-1:0]    col_in,
    input  wire logic [agcb_pkg::DIM_W-1:0]    row_in,
    input  wire logic [agcb_pkg::CODE_W-1:0]   code,
    input  wire logic [agcb_pkg::COLOR_W-1:0]  fg_color,
    input  wire logic [agcb_pkg::COLOR_W-1:0]  bg_color,
    output logic [agcb_pkg::DIM_W-1:0]         col_next,
    output logic [agcb_pkg::DIM_W-1:0]         row_next,
    output logic                               pend,
    output agcb_pkg::lane_res_t                res
);

    logic                              pend_reg, pend_next;
    logic [agcb_pkg::COORD_W-1:0]      x_reg, y_reg;
    logic                              last_reg;
    logic [agcb_pkg::CODE_W-1:0]       code_reg;
    logic [agcb_pkg::DIM_W-1:0]        col_inc;
    logic                              vis;

    always_comb
    begin
        col_inc = col_in + 7'd1;
        if (col_inc == geom.width)
        begin
            col_next = '0;
            row_next = row_in + 7'd1;
        end
        else
        begin
            col_next = col_inc;
            row_next = row_in;
        end
        vis = active && (row_in < geom.height)
            && (row_in >= geom.start_row) && (row_in < geom.end_row)
            && (col_in >= geom.start_col) && (col_in < geom.end_col);
        if (load)
            pend_next = vis;
        else if (take)
            pend_next = 1'b0;
        else
            pend_next = pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else
            pend_reg <= pend_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= geom.org_x + agcb_pkg::COORD_W'(col_in)
                      - agcb_pkg::COORD_W'(geom.start_col);
            y_reg    <= geom.org_y + agcb_pkg::COORD_W'(row_in)
                      - agcb_pkg::COORD_W'(geom.start_row);
            last_reg <= (row_in == geom.end_row - 7'd1)
                     && (col_in == geom.end_col - 7'd1);
            code_reg <= code;
        end
    end

    assign pend      = pend_reg;
    assign res.x     = x_reg;
    assign res.y     = y_reg;
    assign res.last  = last_reg;
    assign res.color = agcb_pkg::blend(fg_color, bg_color, code_reg);

endmodule

`default_nettype wire

@@ rtl/core/agcb_merge.sv @@
`default_nettype none

// Drains the window or the pending lanes, lowest lane first, into the
// output register.
module agcb_merge (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic [agcb_pkg::LANES-1:0]                 lane_pend,
    input  wire agcb_pkg::lane_res_t [agcb_pkg::LANES-1:0]  lane_res,
    input  wire logic                                       win_load,
    input  wire agcb_pkg::out_t                             win_item,
    input  wire logic                                       out_ready,
    output logic [agcb_pkg::LANES-1:0]                      lane_take,
    output logic                                            slot_free,
    output logic                                            out_valid,
    output agcb_pkg::out_t                                  out_item
);

    logic                          win_pend_reg, win_pend_next;
    agcb_pkg::out_t                win_reg;
    logic                          out_valid_reg, out_valid_next;
    agcb_pkg::out_t                out_reg;
    logic                          can_load, any_pend, single;
    logic [agcb_pkg::LANE_W-1:0]   sel;
    agcb_pkg::out_t                pick;

    always_comb
    begin
        sel = '0;
        for (int i = agcb_pkg::LANES - 1; i >= 0; i--)
        begin
            if (lane_pend[i])
                sel = agcb_pkg::LANE_W'(i);
        end
        can_load = !out_valid_reg || out_ready;
        any_pend = win_pend_reg || (lane_pend != '0);
        single   = win_pend_reg ? (lane_pend == '0)
                                : ((lane_pend & (lane_pend - 1'b1)) == '0);
        slot_free = !any_pend || (can_load && single);

        lane_take = '0;
        if (can_load && !win_pend_reg)
            lane_take[sel] = lane_pend[sel];

        if (win_pend_reg)
            pick = win_reg;
        else
        begin
            pick.kind   = agcb_pkg::KIND_PIXEL;
            pick.left   = lane_res[sel].x;
            pick.top    = lane_res[sel].y;
            pick.right  = '0;
            pick.bottom = '0;
            pick.color  = lane_res[sel].color;
            pick.last   = lane_res[sel].last;
        end

        if (win_load)
            win_pend_next = 1'b1;
        else if (can_load)
            win_pend_next = 1'b0;
        else
            win_pend_next = win_pend_reg;

        out_valid_next = can_load ? any_pend : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_pend_reg  <= win_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_load)
            win_reg <= win_item;
        if (can_load && any_pend)
            out_reg <= pick;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire

@@ rtl/core/alpha_glyph_clip_blend_unit.sv @@
`default_nettype none

// Antialiased glyph blitter. A header transfer (tuser 0) places one glyph
// bitmap at (pen_x + offset_x, pen_y + baseline_offset + offset_y), clips it
// to the SCREEN_WIDTH x SCREEN_HEIGHT screen and, if anything is visible and
// the visible area is within MAX_AREA, sends one window result (tuser 0)
// with the clipped rectangle. Data transfers (tuser 1) follow, each with four
// 2-bit alpha codes, low bits first, in row-major bitmap order; every visible
// pixel comes out as a pixel result (tuser 1) with its screen coordinate and
// the RGB565 blend of fg_color over bg_color, tlast marking the bottom-right
// visible pixel. Surplus codes past the bitmap end are dropped, data with no
// glyph open is swallowed, and a new header abandons any open glyph.
// Four lanes handle the codes of one data byte together, and the output
// register drains one result per cycle while m_axis_tready is high; a data
// byte holds s_axis_tready low until at most one of its pixels is left.
// A header holds s_axis_tready low behind its transfer while the
// three-stage placement and clip pipeline runs; its window result then
// passes through the merge window register and the output register. A new
// item is taken while results still wait at the output. Configuration is a
// one-cycle write, always ready; write only while idle.
module alpha_glyph_clip_blend_unit #(
    parameter int SCREEN_WIDTH  = agcb_pkg::DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = agcb_pkg::DEFAULT_SCREEN_HEIGHT,
    parameter int MAX_AREA      = agcb_pkg::DEFAULT_MAX_AREA
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // pen_x[11:0], pen_y[23:12], glyph_width[30:24], glyph_height[37:31],
    // offset_x[44:38], offset_y[51:45], alpha_byte[59:52], zero[63:60]
    input  wire logic [agcb_pkg::IN_W-1:0]     s_axis_tdata,
    // mode: 0 header, 1 data byte
    input  wire logic                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // left[9:0], top[19:10], right[29:20], bottom[39:30], color[55:40]
    output logic [agcb_pkg::OUT_W-1:0]         m_axis_tdata,
    // kind: 0 window, 1 pixel
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [agcb_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [agcb_pkg::COLOR_W-1:0]  cfg_data
);

    localparam int LANES = agcb_pkg::LANES;
    localparam int DW    = agcb_pkg::DIM_W;

    // configuration registers
    logic [agcb_pkg::COLOR_W-1:0]   fg_reg, bg_reg;
    logic [agcb_pkg::BASE_W-1:0]    base_reg;

    // open glyph state
    agcb_pkg::geom_t                geom_reg;
    logic [DW-1:0]                  col_reg, row_reg;
    logic                           active_reg;

    logic                           in_xfer, hdr_xfer, data_xfer;
    logic                           hdr_busy, slot_free;
    agcb_pkg::hdr_res_t             hdr_res;
    agcb_pkg::out_t                 win_item, out_item;
    logic                           out_valid;

    logic [DW-1:0]                  col_chain [LANES+1];
    logic [DW-1:0]                  row_chain [LANES+1];
    logic [LANES-1:0]               lane_pend, lane_take;
    agcb_pkg::lane_res_t [LANES-1:0] lane_res;

    logic [7:0]                     alpha_byte;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = slot_free && !hdr_busy;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign hdr_xfer      = in_xfer && (s_axis_tuser == agcb_pkg::MODE_HEADER);
    assign data_xfer     = in_xfer && (s_axis_tuser == agcb_pkg::MODE_DATA);
    assign alpha_byte    = s_axis_tdata[59:52];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg   <= agcb_pkg::FG_RESET;
            bg_reg   <= agcb_pkg::BG_RESET;
            base_reg <= agcb_pkg::BASE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                agcb_pkg::CFG_FG_COLOR: fg_reg   <= cfg_data;
                agcb_pkg::CFG_BG_COLOR: bg_reg   <= cfg_data;
                agcb_pkg::CFG_BASELINE: base_reg <= cfg_data[agcb_pkg::BASE_W-1:0];
                default:                ;
            endcase
        end
    end

    agcb_hdr #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAX_AREA      (MAX_AREA)
    ) u_hdr (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (hdr_xfer),
        .pen_x           ($signed(s_axis_tdata[11:0])),
        .pen_y           ($signed(s_axis_tdata[23:12])),
        .glyph_width     (s_axis_tdata[30:24]),
        .glyph_height    (s_axis_tdata[37:31]),
        .offset_x        ($signed(s_axis_tdata[44:38])),
        .offset_y        ($signed(s_axis_tdata[51:45])),
        .baseline_offset (base_reg),
        .busy            (hdr_busy),
        .res             (hdr_res)
    );

    // Lane k looks at bitmap pixel pixel_index + k; the walk carries
    // column and row from lane to lane, wrapping at the bitmap width.
    assign col_chain[0] = col_reg;
    assign row_chain[0] = row_reg;

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        agcb_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (data_xfer),
            .take     (lane_take[k]),
            .active   (active_reg),
            .geom     (geom_reg),
            .col_in   (col_chain[k]),
            .row_in   (row_chain[k]),
            .code     (alpha_byte[2*k +: agcb_pkg::CODE_W]),
            .fg_color (fg_reg),
            .bg_color (bg_reg),
            .col_next (col_chain[k+1]),
            .row_next (row_chain[k+1]),
            .pend     (lane_pend[k]),
            .res      (lane_res[k])
        );
    end

    // glyph open/close and bitmap walk position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
            geom_reg   <= '0;
        end
        else if (hdr_res.load)
        begin
            active_reg <= 1'b1;
            col_reg    <= '0;
            row_reg    <= '0;
            geom_reg   <= hdr_res.geom;
        end
        else if (hdr_xfer)
        begin
            active_reg <= 1'b0;
        end
        else if (data_xfer && active_reg)
        begin
            col_reg    <= col_chain[LANES];
            row_reg    <= row_chain[LANES];
            active_reg <= (row_chain[LANES] < geom_reg.height);
        end
    end

    always_comb
    begin
        win_item.kind   = agcb_pkg::KIND_WINDOW;
        win_item.left   = hdr_res.geom.org_x;
        win_item.top    = hdr_res.geom.org_y;
        win_item.right  = hdr_res.right;
        win_item.bottom = hdr_res.bottom;
        win_item.color  = '0;
        win_item.last   = 1'b0;
    end

    agcb_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_pend (lane_pend),
        .lane_res  (lane_res),
        .win_load  (hdr_res.load),
        .win_item  (win_item),
        .out_ready (m_axis_tready),
        .lane_take (lane_take),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {out_item.color, out_item.bottom, out_item.right,
                            out_item.top, out_item.left};
    assign m_axis_tuser  = out_item.kind;
    assign m_axis_tlast  = out_item.last;

endmodule

`default_nettype wire

@@ rtl/core/agcb_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module agcb_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic                          s_axis_tuser,
    input wire logic                          m_axis_tvalid,
    input wire logic [agcb_pkg::OUT_W-1:0]    m_axis_tdata,
    input wire logic                          m_axis_tuser,
    input wire logic                          m_axis_tlast
);

    // only pixels close a glyph
    `AGCB_ASSERT_IMP(a_last_is_pixel, m_axis_tvalid && m_axis_tlast, m_axis_tuser)
    // windows carry no color
    `AGCB_ASSERT_IMP(a_window_no_color, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[55:40] == '0)
    // pixels carry no far corner
    `AGCB_ASSERT_IMP(a_pixel_no_corner, m_axis_tvalid && m_axis_tuser, m_axis_tdata[39:20] == '0)
    // header placement holds off input for the next cycle
    `AGCB_ASSERT_NXT(a_hdr_holds_input, s_axis_tvalid && s_axis_tready && !s_axis_tuser, !s_axis_tready)

endmodule

bind alpha_glyph_clip_blend_unit agcb_checker u_agcb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
